// ===== rtl/dscp_pkg.sv =====
// Shared constants, codes and control structs of the sector character packer.
package dscp_pkg;

   // Default configuration of the sector geometry.
   localparam int SECTOR_WORDS_DEF = 64;
   localparam int PACKET_WORDS_DEF = 16;
   localparam int ADDRESS_BITS_DEF = 18;

   // Fixed field widths of the channels.
   localparam int OPCODE_W    = 3;
   localparam int KIND_W      = 2;
   localparam int CHAR_W      = 6;
   localparam int WORD_W      = 27;
   localparam int PORT_ADDR_W = 18;
   localparam int POS_W       = 6;
   localparam int CSR_INDEX_W = 2;

   // Operation codes of a request.
   localparam logic [OPCODE_W-1:0] OP_CONNECT  = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_SET_ADDR = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_READ     = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_WRITE    = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_DISC     = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_WEOR     = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_LOAD     = 3'd6;

   // Kinds of response.
   localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FETCH = 2'd2;
   localparam logic [KIND_W-1:0] KIND_WORD  = 2'd3;

   // Sources of the buffer read address.
   localparam logic [1:0] RD_PTR   = 2'd0;
   localparam logic [1:0] RD_ZERO  = 2'd1;
   localparam logic [1:0] RD_FLUSH = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACHED = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCKED   = 2'd1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              accept;
      logic              connect;
      logic              set_addr;
      logic              load;
      logic              end_op;
      logic              end_eor;
      logic              end_err;
      logic              cap_binary;
      logic              ram_re;
      logic [1:0]        rd_src;
      logic              wr_char;
      logic              wr_pad;
      logic              wr_hdr;
      logic              rd_char;
      logic              scan_init;
      logic              scan_step;
      logic              fl_init;
      logic              emit;
      logic [KIND_W-1:0] emit_kind;
   } dscp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic                ptr_ge_len;
      logic                ptr_ge_sector;
      logic                ptr_zero;
      logic                len_zero;
      logic                drive_attached;
      logic                write_ok;
      logic                scan_done;
      logic                pad_done;
      logic                fl_last;
      logic                out_free;
      logic                any_out;
   } dscp_sts_type;

endpackage

// ===== rtl/dscp_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module dscp_ram
   import dscp_pkg::*;
#(
   parameter int WIDTH = WORD_W,
   parameter int DEPTH = SECTOR_WORDS_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/dscp_ctrl.sv =====
// Controller state machine that sequences each request through the datapath.
module dscp_ctrl
   import dscp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  dscp_sts_type sts,
   output dscp_cmd_type cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DEC     = 4'd1;
   localparam logic [3:0] S_RD_WAIT = 4'd2;
   localparam logic [3:0] S_RD_OUT  = 4'd3;
   localparam logic [3:0] S_FETCH   = 4'd4;
   localparam logic [3:0] S_WR_RD   = 4'd5;
   localparam logic [3:0] S_WR_WAIT = 4'd6;
   localparam logic [3:0] S_SCAN    = 4'd7;
   localparam logic [3:0] S_PAD_RD  = 4'd8;
   localparam logic [3:0] S_PAD_WR  = 4'd9;
   localparam logic [3:0] S_HDR_RD  = 4'd10;
   localparam logic [3:0] S_HDR_WR  = 4'd11;
   localparam logic [3:0] S_FL_RD   = 4'd12;
   localparam logic [3:0] S_FL_OUT  = 4'd13;
   localparam logic [3:0] S_FIN     = 4'd14;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // Only one request is in work at a time.
   assign req_stall = (state_ff != S_IDLE);

   // Next state and command decode.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DEC;
            end
         end
         S_DEC: begin
            case (sts.opcode)
               OP_CONNECT: begin
                  cmd.connect = 1'b1;
                  state_in    = S_FIN;
               end
               OP_SET_ADDR: begin
                  cmd.set_addr = 1'b1;
                  state_in     = S_FIN;
               end
               OP_READ: begin
                  if (sts.ptr_ge_len) begin
                     if (!sts.drive_attached) begin
                        cmd.end_op  = 1'b1;
                        cmd.end_eor = 1'b1;
                        cmd.end_err = 1'b1;
                        state_in    = S_FIN;
                     end else begin
                        state_in = S_FETCH;
                     end
                  end else begin
                     cmd.ram_re = 1'b1;
                     cmd.rd_src = RD_PTR;
                     state_in   = S_RD_WAIT;
                  end
               end
               OP_WRITE: begin
                  if (sts.ptr_ge_sector) begin
                     if (sts.write_ok) begin
                        cmd.fl_init = 1'b1;
                        state_in    = S_FL_RD;
                     end else begin
                        cmd.end_op  = 1'b1;
                        cmd.end_eor = 1'b1;
                        cmd.end_err = 1'b1;
                        state_in    = S_FIN;
                     end
                  end else begin
                     cmd.ram_re = 1'b1;
                     cmd.rd_src = RD_PTR;
                     state_in   = S_WR_WAIT;
                  end
               end
               OP_DISC: begin
                  cmd.end_op     = 1'b1;
                  cmd.cap_binary = 1'b1;
                  if (sts.len_zero && !sts.ptr_zero) begin
                     cmd.scan_init = 1'b1;
                     state_in      = S_SCAN;
                  end else begin
                     state_in = S_FIN;
                  end
               end
               OP_WEOR: begin
                  cmd.end_op     = 1'b1;
                  cmd.end_eor    = 1'b1;
                  cmd.cap_binary = 1'b1;
                  if (!sts.ptr_zero) begin
                     cmd.scan_init = 1'b1;
                     state_in      = S_SCAN;
                  end else begin
                     state_in = S_FIN;
                  end
               end
               OP_LOAD: begin
                  cmd.load = 1'b1;
                  state_in = S_FIN;
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_RD_WAIT: begin
            cmd.rd_char = 1'b1;
            state_in    = S_RD_OUT;
         end
         S_RD_OUT: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_CHAR;
               state_in      = S_FIN;
            end
         end
         S_FETCH: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_FETCH;
               state_in      = S_FIN;
            end
         end
         S_WR_RD: begin
            cmd.ram_re = 1'b1;
            cmd.rd_src = RD_PTR;
            state_in   = S_WR_WAIT;
         end
         S_WR_WAIT: begin
            cmd.wr_char = 1'b1;
            state_in    = S_FIN;
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_PAD_RD;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_PAD_RD: begin
            if (sts.pad_done) begin
               state_in = S_HDR_RD;
            end else begin
               cmd.ram_re = 1'b1;
               cmd.rd_src = RD_PTR;
               state_in   = S_PAD_WR;
            end
         end
         S_PAD_WR: begin
            cmd.wr_pad = 1'b1;
            state_in   = S_PAD_RD;
         end
         S_HDR_RD: begin
            cmd.ram_re = 1'b1;
            cmd.rd_src = RD_ZERO;
            state_in   = S_HDR_WR;
         end
         S_HDR_WR: begin
            cmd.wr_hdr = 1'b1;
            if (sts.write_ok) begin
               cmd.fl_init = 1'b1;
               state_in    = S_FL_RD;
            end else begin
               cmd.end_op  = 1'b1;
               cmd.end_eor = 1'b1;
               cmd.end_err = 1'b1;
               state_in    = S_FIN;
            end
         end
         S_FL_RD: begin
            cmd.ram_re = 1'b1;
            cmd.rd_src = RD_FLUSH;
            state_in   = S_FL_OUT;
         end
         S_FL_OUT: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_WORD;
               if (sts.fl_last) begin
                  state_in = (sts.opcode == OP_WRITE) ? S_WR_RD : S_FIN;
               end else begin
                  state_in = S_FL_RD;
               end
            end
         end
         S_FIN: begin
            if (sts.any_out) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_ACK;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/dscp_dpath.sv =====
// Datapath: sector buffer, pointers, address, flags and the response register.
module dscp_dpath
   import dscp_pkg::*;
#(
   parameter int SECTOR_WORDS = SECTOR_WORDS_DEF,
   parameter int PACKET_WORDS = PACKET_WORDS_DEF,
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dscp_cmd_type           cmd,
   output dscp_sts_type           sts,
   input  logic                   drive_attached,
   input  logic                   write_locked,
   input  logic [OPCODE_W-1:0]    req_opcode,
   input  logic                   req_binary_mode,
   input  logic [PORT_ADDR_W-1:0] req_sector_address,
   input  logic [CHAR_W-1:0]      req_char_in,
   input  logic [WORD_W-1:0]      req_disk_word,
   input  logic [POS_W-1:0]       req_word_index,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [KIND_W-1:0]      rsp_kind,
   output logic [CHAR_W-1:0]      rsp_char_out,
   output logic [PORT_ADDR_W-1:0] rsp_address_out,
   output logic [WORD_W-1:0]      rsp_word_out,
   output logic [POS_W-1:0]       rsp_word_pos,
   output logic                   rsp_last,
   output logic                   rsp_end_of_record,
   output logic                   rsp_error,
   output logic                   rsp_error_flag
);

   localparam int SC    = SECTOR_WORDS * 4;
   localparam int PC    = PACKET_WORDS * 4;
   localparam int NPKT  = SECTOR_WORDS / PACKET_WORDS;
   localparam int AW    = $clog2(SECTOR_WORDS);
   localparam int PTR_W = $clog2(SC + 1);
   localparam int BND_W = $clog2(SC + PC + 1);
   localparam int PK_W  = $clog2(NPKT + 2) + 1;

   // Latched request.
   logic [OPCODE_W-1:0]    it_op_ff;
   logic                   it_bin_ff;
   logic [PORT_ADDR_W-1:0] it_addr_ff;
   logic [CHAR_W-1:0]      it_ch_ff;
   logic [WORD_W-1:0]      it_word_ff;
   logic [POS_W-1:0]       it_idx_ff;

   // Buffer control state.
   logic [PTR_W-1:0]        ptr_ff;
   logic [PTR_W-1:0]        len_ff;
   logic [ADDRESS_BITS-1:0] addr_ff;
   logic                    op_bin_ff;
   logic                    sticky_ff;
   logic                    fill_bin_ff;
   logic [2:0]              hdr_ff;
   logic [SECTOR_WORDS-1:0] vld_ff;
   logic                    vld_q_ff;
   logic [BND_W-1:0]        bound_ff;
   logic [PK_W-1:0]         pk_ff;
   logic [AW-1:0]           fi_ff;
   logic [CHAR_W-1:0]       char_ff;
   logic                    item_eor_ff;
   logic                    item_err_ff;
   logic                    any_out_ff;

   // Response register.
   logic                   rsp_valid_ff;
   logic [KIND_W-1:0]      kind_ff;
   logic [CHAR_W-1:0]      char_out_ff;
   logic [PORT_ADDR_W-1:0] addr_out_ff;
   logic [WORD_W-1:0]      word_out_ff;
   logic [POS_W-1:0]       pos_ff;
   logic                   last_ff;
   logic                   eor_ff;
   logic                   err_ff;
   logic                   eflag_ff;

   // Buffer memory ports.
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic [AW-1:0]     ram_raddr;
   logic [WORD_W-1:0] ram_rdata;
   logic [WORD_W-1:0] rd_word;
   logic [AW-1:0]     wptr;

   // Derived control values.
   logic              load_we;
   logic              load_done;
   logic              rd_end;
   logic              end_any;
   logic              eor_any;
   logic              fl_last;
   logic              fl_done;
   logic [BND_W-1:0]  pktend;
   logic [PK_W-1:0]   pkts_fill;
   logic [PK_W-1:0]   hfield_full;
   logic [2:0]        hdr_bits;
   logic [1:0]        field;
   logic [PK_W-1:0]   pkts_load;
   logic [PTR_W-1:0]  ptr_inc;
   logic [CHAR_W-1:0] char_sel;

   dscp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SECTOR_WORDS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Words never written since the last clear read as zero.
   assign rd_word = vld_q_ff ? ram_rdata : '0;
   assign wptr    = AW'(ptr_ff[PTR_W-1:2]);
   assign ptr_inc = ptr_ff + PTR_W'(1);

   // Read address selection.
   always_comb begin
      case (cmd.rd_src)
         RD_PTR:   ram_raddr = wptr;
         RD_FLUSH: ram_raddr = fi_ff;
         default:  ram_raddr = '0;
      endcase
   end

   // Load word handling and packet count of a loaded sector.
   assign load_we   = cmd.load && (int'(it_idx_ff) < SECTOR_WORDS);
   assign load_done = cmd.load && (int'(it_idx_ff) == SECTOR_WORDS - 1);
   assign field     = hdr_ff[1:0];
   assign pkts_load = (NPKT > int'(field)) ? (PK_W'(NPKT) - PK_W'(field)) : PK_W'(1);

   // Packet boundary of a fill and the header it leaves in word 0.
   assign pktend      = (bound_ff > BND_W'(SC)) ? BND_W'(SC) : bound_ff;
   assign pkts_fill   = (bound_ff > BND_W'(SC)) ? PK_W'(NPKT) : pk_ff;
   assign hfield_full = PK_W'(NPKT) - pkts_fill;
   assign hdr_bits    = {~fill_bin_ff, hfield_full[1:0]};

   // Write port selection.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = wptr;
      ram_wdata = {3'b000, rd_word[17:0], it_ch_ff};
      if (cmd.wr_char) begin
         ram_we = 1'b1;
      end else if (cmd.wr_pad) begin
         ram_we    = 1'b1;
         ram_wdata = {3'b000, rd_word[17:0], {CHAR_W{1'b0}}};
      end else if (cmd.wr_hdr) begin
         ram_we    = 1'b1;
         ram_waddr = '0;
         ram_wdata = rd_word | {hdr_bits, 24'd0};
      end else if (load_we) begin
         ram_we    = 1'b1;
         ram_waddr = AW'(it_idx_ff);
         ram_wdata = it_word_ff;
      end
   end

   // Character extraction, most significant character first.
   always_comb begin
      case (ptr_ff[1:0])
         2'd0:    char_sel = rd_word[23:18];
         2'd1:    char_sel = rd_word[17:12];
         2'd2:    char_sel = rd_word[11:6];
         default: char_sel = rd_word[5:0];
      endcase
   end

   // End of record when the last character of a record is read.
   assign rd_end  = (ptr_inc >= len_ff) && (op_bin_ff || hdr_ff[2]);
   assign end_any = cmd.end_op || (cmd.rd_char && rd_end);
   assign eor_any = cmd.end_eor || cmd.end_err || (cmd.rd_char && rd_end);

   assign fl_last = (fi_ff == AW'(SECTOR_WORDS - 1));
   assign fl_done = cmd.emit && (cmd.emit_kind == KIND_WORD) && fl_last;

   // Latch the request on transfer.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         it_op_ff   <= req_opcode;
         it_bin_ff  <= req_binary_mode;
         it_addr_ff <= req_sector_address;
         it_ch_ff   <= req_char_in;
         it_word_ff <= req_disk_word;
         it_idx_ff  <= req_word_index;
      end
   end

   // Buffer pointers, address, header shadow and valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         len_ff      <= '0;
         addr_ff     <= '0;
         op_bin_ff   <= 1'b0;
         sticky_ff   <= 1'b0;
         fill_bin_ff <= 1'b0;
         hdr_ff      <= '0;
         vld_ff      <= '0;
         item_eor_ff <= 1'b0;
         item_err_ff <= 1'b0;
         any_out_ff  <= 1'b0;
      end else begin
         if (cmd.accept) begin
            item_eor_ff <= 1'b0;
            item_err_ff <= 1'b0;
            any_out_ff  <= 1'b0;
         end
         if (cmd.emit) begin
            any_out_ff <= 1'b1;
         end
         if (cmd.cap_binary) begin
            fill_bin_ff <= op_bin_ff;
         end
         if (end_any) begin
            op_bin_ff <= 1'b0;
         end
         if (eor_any) begin
            item_eor_ff <= 1'b1;
         end
         if (cmd.end_err) begin
            item_err_ff <= 1'b1;
            sticky_ff   <= 1'b1;
         end
         if (cmd.set_addr) begin
            addr_ff <= ADDRESS_BITS'(it_addr_ff);
         end
         if (load_done || fl_done) begin
            addr_ff <= addr_ff + ADDRESS_BITS'(1);
         end
         if (cmd.wr_char || cmd.wr_pad || cmd.rd_char) begin
            ptr_ff <= ptr_inc;
         end
         if (load_done) begin
            ptr_ff <= '0;
            len_ff <= PTR_W'(int'(pkts_load) * PC);
         end
         // Header shadow of the top bits of word 0.
         if ((cmd.wr_char || cmd.wr_pad) && (wptr == '0)) begin
            hdr_ff <= '0;
         end
         if (cmd.wr_hdr) begin
            hdr_ff <= hdr_ff | hdr_bits;
         end
         if (load_we && (it_idx_ff == '0)) begin
            hdr_ff <= it_word_ff[26:24];
         end
         if (ram_we) begin
            vld_ff[ram_waddr] <= 1'b1;
         end
         // Connect and a completed flush empty the buffer.
         if (cmd.connect) begin
            op_bin_ff <= it_bin_ff;
            ptr_ff    <= '0;
            len_ff    <= '0;
            hdr_ff    <= '0;
            vld_ff    <= '0;
         end
         if (fl_done) begin
            ptr_ff <= '0;
            hdr_ff <= '0;
            vld_ff <= '0;
         end
      end
   end

   // Fill scan, flush index, read valid and captured character.
   always_ff @(posedge clock) begin
      if (cmd.ram_re) begin
         vld_q_ff <= vld_ff[ram_raddr];
      end
      if (cmd.scan_init) begin
         bound_ff <= BND_W'(PC);
         pk_ff    <= PK_W'(1);
      end else if (cmd.scan_step) begin
         bound_ff <= bound_ff + BND_W'(PC);
         pk_ff    <= pk_ff + PK_W'(1);
      end
      if (cmd.fl_init) begin
         fi_ff <= '0;
      end else if (cmd.emit && (cmd.emit_kind == KIND_WORD)) begin
         fi_ff <= fi_ff + AW'(1);
      end
      if (cmd.rd_char) begin
         char_ff <= char_sel;
      end
   end

   // Response register: loads when empty or when its transfer completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         kind_ff     <= cmd.emit_kind;
         char_out_ff <= (cmd.emit_kind == KIND_CHAR) ? char_ff : '0;
         addr_out_ff <= PORT_ADDR_W'(addr_ff);
         word_out_ff <= (cmd.emit_kind == KIND_WORD) ? rd_word : '0;
         pos_ff      <= (cmd.emit_kind == KIND_WORD) ? POS_W'(fi_ff) : '0;
         last_ff     <= (cmd.emit_kind != KIND_WORD) || fl_last;
         eor_ff      <= item_eor_ff;
         err_ff      <= item_err_ff;
         eflag_ff    <= sticky_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_char_out      = char_out_ff;
   assign rsp_address_out   = addr_out_ff;
   assign rsp_word_out      = word_out_ff;
   assign rsp_word_pos      = pos_ff;
   assign rsp_last          = last_ff;
   assign rsp_end_of_record = eor_ff;
   assign rsp_error         = err_ff;
   assign rsp_error_flag    = eflag_ff;

   // Status to the controller.
   always_comb begin
      sts                = '0;
      sts.opcode         = it_op_ff;
      sts.ptr_ge_len     = (ptr_ff >= len_ff);
      sts.ptr_ge_sector  = (ptr_ff >= PTR_W'(SC));
      sts.ptr_zero       = (ptr_ff == '0);
      sts.len_zero       = (len_ff == '0);
      sts.drive_attached = drive_attached;
      sts.write_ok       = drive_attached && !write_locked;
      sts.scan_done      = (bound_ff >= BND_W'(ptr_ff));
      sts.pad_done       = (BND_W'(ptr_ff) >= pktend);
      sts.fl_last        = fl_last;
      sts.out_free       = !rsp_valid_ff || !rsp_stall;
      sts.any_out        = any_out_ff;
   end

endmodule

// ===== rtl/disk_sector_char_packer_top.sv =====
// Top level of the disk sector character packer: configuration and the two units.
//
// Usage: requests arrive on the req_ channel (valid/stall); one transfer carries an
// opcode and its operands. Each request gives one or more responses on the rsp_
// channel, the final one marked by rsp_last. The csr_ channel (valid/ready, always
// ready) writes the drive-attached and write-lock bits; write it only while idle.
// Requests are handled one at a time: req_stall is high from the transfer until the
// sequencer is back in idle. A sector flush reads each word through the buffer RAM's
// registered read port and then emits it, one word at a time; a fill first scans
// the packets up to the write pointer, then pads each remaining character of the
// last packet with a buffer read and a write, then reads and writes the header.
// A new request is taken while the last response still waits.
// If the receiver stalls, the response register holds and the sequencer waits.
// Reset clears all control state, the sticky error and the buffer valid bits at
// once (no clearing pass); the buffer reads as all zero afterwards.
module disk_sector_char_packer_top
   import dscp_pkg::*;
#(
   parameter int SECTOR_WORDS = SECTOR_WORDS_DEF,
   parameter int PACKET_WORDS = PACKET_WORDS_DEF,
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OPCODE_W-1:0]    req_opcode,
   input  logic                   req_binary_mode,
   input  logic [PORT_ADDR_W-1:0] req_sector_address,
   input  logic [CHAR_W-1:0]      req_char_in,
   input  logic [WORD_W-1:0]      req_disk_word,
   input  logic [POS_W-1:0]       req_word_index,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [KIND_W-1:0]      rsp_kind,
   output logic [CHAR_W-1:0]      rsp_char_out,
   output logic [PORT_ADDR_W-1:0] rsp_address_out,
   output logic [WORD_W-1:0]      rsp_word_out,
   output logic [POS_W-1:0]       rsp_word_pos,
   output logic                   rsp_last,
   output logic                   rsp_end_of_record,
   output logic                   rsp_error,
   output logic                   rsp_error_flag,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic                   csr_wdata
);

   logic         attached_ff;
   logic         locked_ff;
   dscp_cmd_type cmd;
   dscp_sts_type sts;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         attached_ff <= 1'b0;
         locked_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ATTACHED: attached_ff <= csr_wdata;
            CSR_LOCKED:   locked_ff   <= csr_wdata;
            default:      ;
         endcase
      end
   end

   dscp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dscp_dpath #(
      .SECTOR_WORDS (SECTOR_WORDS),
      .PACKET_WORDS (PACKET_WORDS),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .drive_attached     (attached_ff),
      .write_locked       (locked_ff),
      .req_opcode         (req_opcode),
      .req_binary_mode    (req_binary_mode),
      .req_sector_address (req_sector_address),
      .req_char_in        (req_char_in),
      .req_disk_word      (req_disk_word),
      .req_word_index     (req_word_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_char_out       (rsp_char_out),
      .rsp_address_out    (rsp_address_out),
      .rsp_word_out       (rsp_word_out),
      .rsp_word_pos       (rsp_word_pos),
      .rsp_last           (rsp_last),
      .rsp_end_of_record  (rsp_end_of_record),
      .rsp_error          (rsp_error),
      .rsp_error_flag     (rsp_error_flag)
   );

endmodule

// ===== rtl/dscp_checker.sv =====
// Port-level checker of the sector character packer and its bind to the top level.
module dscp_checker
   import dscp_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [KIND_W-1:0] rsp_kind,
   input logic              rsp_last,
   input logic              rsp_end_of_record,
   input logic              rsp_error,
   input logic              rsp_error_flag
);

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_last))
      else $error("stalled response changed");

   // The block works on one request at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in work");

   // Only sector words come in runs; every other response ends its request.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_WORD) |-> rsp_last)
      else $error("non-word response without last");

   // An error ends the record and is reflected in the sticky flag.
   a_err_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_end_of_record && rsp_error_flag)
      else $error("error without end of record or sticky flag");

endmodule

bind disk_sector_char_packer_top dscp_checker u_dscp_checker (.*);

// ===== tb/tb_disk_sector_char_packer_top.sv =====
// Self-checking testbench of the disk sector character packer with a built-in predictor.
`timescale 1ns / 1ps

module tb_disk_sector_char_packer_top;
   import dscp_pkg::*;

   localparam int NUM_WORDS  = 64;
   localparam int PKT_WORDS  = 16;
   localparam int NUM_PKTS   = NUM_WORDS / PKT_WORDS;
   localparam int NUM_CHARS  = NUM_WORDS * 4;
   localparam int PKT_CHARS  = PKT_WORDS * 4;
   localparam logic [OPCODE_W-1:0] OP_SPARE = 3'd7;
   localparam logic [23:0] MASK24 = 24'hFFFFFF;

   typedef struct packed {
      logic [OPCODE_W-1:0]    opcode;
      logic                   binary_mode;
      logic [PORT_ADDR_W-1:0] sector_address;
      logic [CHAR_W-1:0]      char_in;
      logic [WORD_W-1:0]      disk_word;
      logic [POS_W-1:0]       word_index;
   } request_type;

   typedef struct packed {
      logic [KIND_W-1:0]      kind;
      logic [CHAR_W-1:0]      char_out;
      logic [PORT_ADDR_W-1:0] address_out;
      logic [WORD_W-1:0]      word_out;
      logic [POS_W-1:0]       word_pos;
      logic                   last;
      logic                   end_of_record;
      logic                   error;
      logic                   error_flag;
   } response_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [OPCODE_W-1:0]    req_opcode;
   logic                   req_binary_mode;
   logic [PORT_ADDR_W-1:0] req_sector_address;
   logic [CHAR_W-1:0]      req_char_in;
   logic [WORD_W-1:0]      req_disk_word;
   logic [POS_W-1:0]       req_word_index;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [KIND_W-1:0]      rsp_kind;
   logic [CHAR_W-1:0]      rsp_char_out;
   logic [PORT_ADDR_W-1:0] rsp_address_out;
   logic [WORD_W-1:0]      rsp_word_out;
   logic [POS_W-1:0]       rsp_word_pos;
   logic                   rsp_last;
   logic                   rsp_end_of_record;
   logic                   rsp_error;
   logic                   rsp_error_flag;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic                   csr_wdata;

   disk_sector_char_packer_top u_top (.*);

   // Predictor copy of the sector buffer state and configuration.
   logic [WORD_W-1:0]      sector_mem [NUM_WORDS];
   logic [8:0]             char_ptr;
   logic [8:0]             char_len;
   logic [PORT_ADDR_W-1:0] cur_addr;
   logic                   is_active;
   logic                   is_binary;
   logic                   err_sticky;
   logic                   cfg_attached;
   logic                   cfg_locked;

   request_type  pending_reqs[$];
   response_type expected_rsps[$];
   int           fail_count;
   int           req_total;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Per-item end flags gathered while predicting one request.
   logic item_eor, item_err;
   response_type item_rsps[$];

   function automatic void finish_op(input logic eor, input logic err);
      is_active = 1'b0;
      is_binary = 1'b0;
      if (eor || err) item_eor = 1'b1;
      if (err) begin
         item_err   = 1'b1;
         err_sticky = 1'b1;
      end
   endfunction

   function automatic void add_rsp(input logic [KIND_W-1:0] kind,
                                   input logic [CHAR_W-1:0] ch,
                                   input logic [WORD_W-1:0] word,
                                   input logic [POS_W-1:0] pos);
      response_type r;
      r = '{kind, ch, cur_addr, word, pos, 1'b0, 1'b0, 1'b0, 1'b0};
      item_rsps.push_back(r);
   endfunction

   // Sends the whole sector out as write words; returns 0 on a drive fault.
   function automatic logic flush_words();
      if (!cfg_attached || cfg_locked) begin
         finish_op(1'b1, 1'b1);
         return 1'b0;
      end
      for (int i = 0; i < NUM_WORDS; i++) begin
         add_rsp(KIND_WORD, '0, sector_mem[i], POS_W'(i));
      end
      cur_addr = cur_addr + 1'b1;
      char_ptr = '0;
      foreach (sector_mem[i]) sector_mem[i] = '0;
      return 1'b1;
   endfunction

   // Pads a partial sector to a packet boundary, stamps the header and flushes it.
   task automatic pad_and_flush(input logic bin);
      int pkt_end;
      int pkts;
      if (char_ptr == 0) return;
      pkt_end = ((int'(char_ptr) + PKT_CHARS - 1) / PKT_CHARS) * PKT_CHARS;
      if (pkt_end > NUM_CHARS) pkt_end = NUM_CHARS;
      pkts = pkt_end / PKT_CHARS;
      while (int'(char_ptr) < pkt_end) begin
         sector_mem[char_ptr >> 2] = WORD_W'({sector_mem[char_ptr >> 2], 6'd0} & MASK24);
         char_ptr = char_ptr + 1'b1;
      end
      sector_mem[0] = sector_mem[0] | {~bin, 2'(NUM_PKTS - pkts), 24'd0};
      void'(flush_words());
   endtask

   // Works out every response of one accepted request and queues it.
   task automatic predict_request(input request_type rq);
      logic [5:0] widx;
      logic [1:0] field;
      logic [CHAR_W-1:0] c;
      logic bin;
      logic ok;
      int pkts;
      item_eor = 1'b0;
      item_err = 1'b0;
      item_rsps.delete();
      case (rq.opcode)
         OP_CONNECT: begin
            is_active = 1'b1;
            is_binary = rq.binary_mode;
            char_ptr  = '0;
            char_len  = '0;
            foreach (sector_mem[i]) sector_mem[i] = '0;
         end
         OP_SET_ADDR: cur_addr = rq.sector_address;
         OP_READ: begin
            if (char_ptr >= char_len) begin
               if (!cfg_attached) finish_op(1'b1, 1'b1);
               else add_rsp(KIND_FETCH, '0, '0, '0);
            end else begin
               c = '0;
               if ((char_ptr >> 2) < NUM_WORDS)
                  c = CHAR_W'(sector_mem[char_ptr >> 2] >> ((3 - char_ptr[1:0]) * 6));
               char_ptr = char_ptr + 1'b1;
               if (char_ptr >= char_len && (is_binary || sector_mem[0][26]))
                  finish_op(1'b1, 1'b0);
               add_rsp(KIND_CHAR, c, '0, '0);
            end
         end
         OP_WRITE: begin
            ok = 1'b1;
            if (char_ptr >= NUM_CHARS) ok = flush_words();
            if (ok) begin
               sector_mem[char_ptr >> 2] =
                  WORD_W'({sector_mem[char_ptr >> 2], rq.char_in} & MASK24);
               char_ptr = char_ptr + 1'b1;
            end
         end
         OP_DISC: begin
            bin = is_binary;
            finish_op(1'b0, 1'b0);
            if (char_len == 0) pad_and_flush(bin);
         end
         OP_WEOR: begin
            bin = is_binary;
            finish_op(1'b1, 1'b0);
            pad_and_flush(bin);
         end
         OP_LOAD: begin
            widx = rq.word_index;
            sector_mem[widx] = rq.disk_word;
            if (widx == NUM_WORDS - 1) begin
               field    = sector_mem[0][25:24];
               pkts     = (NUM_PKTS > field) ? NUM_PKTS - field : 1;
               char_len = 9'(pkts * PKT_CHARS);
               char_ptr = '0;
               cur_addr = cur_addr + 1'b1;
            end
         end
         default: ;
      endcase
      if (item_rsps.size() == 0) add_rsp(KIND_ACK, '0, '0, '0);
      foreach (item_rsps[k]) begin
         item_rsps[k].last          = (k == item_rsps.size() - 1);
         item_rsps[k].end_of_record = item_eor;
         item_rsps[k].error         = item_err;
         item_rsps[k].error_flag    = err_sticky;
         expected_rsps.push_back(item_rsps[k]);
      end
   endtask

   // Request driver: bursts of transfers separated by random gaps.
   int burst_left;
   int gap_left;
   always @(posedge clock) begin
      request_type rq;
      logic holding;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = $urandom_range(1, 12);
         gap_left   = 0;
      end else begin
         holding = req_valid;
         if (req_valid && !req_stall) begin
            rq = '{req_opcode, req_binary_mode, req_sector_address, req_char_in,
                   req_disk_word, req_word_index};
            predict_request(rq);
            holding = 1'b0;
         end
         if (!holding) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               rq = pending_reqs.pop_front();
               req_valid          <= 1'b1;
               req_opcode         <= rq.opcode;
               req_binary_mode    <= rq.binary_mode;
               req_sector_address <= rq.sector_address;
               req_char_in        <= rq.char_in;
               req_disk_word      <= rq.disk_word;
               req_word_index     <= rq.word_index;
               burst_left = burst_left - 1;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 20);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response stall pattern, with one long hold-off so the block backs up.
   int   stall_mode;
   int   long_hold;
   logic long_done;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode = 0;
         long_hold  = 0;
         long_done  = 1'b0;
      end else begin
         // The long hold-off starts while plenty of requests are still queued.
         if (!long_done && pending_reqs.size() > 30) begin
            long_hold = 400;
            long_done = 1'b1;
         end
         if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
         if (long_hold > 0) begin
            long_hold = long_hold - 1;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Response monitor: compares each transfer with the oldest expectation.
   always @(posedge clock) begin
      response_type want;
      response_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_kind, rsp_char_out, rsp_address_out, rsp_word_out, rsp_word_pos,
                 rsp_last, rsp_end_of_record, rsp_error, rsp_error_flag};
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response kind %0d", $time, got.kind);
            fail_count = fail_count + 1;
         end else begin
            want = expected_rsps.pop_front();
            if (got != want) begin
               $display("%0t: expected k=%0d c=%h a=%h w=%h p=%0d l=%b e=%b r=%b f=%b",
                        $time, want.kind, want.char_out, want.address_out,
                        want.word_out, want.word_pos, want.last, want.end_of_record,
                        want.error, want.error_flag);
               $display("%0t: actual   k=%0d c=%h a=%h w=%h p=%0d l=%b e=%b r=%b f=%b",
                        $time, got.kind, got.char_out, got.address_out,
                        got.word_out, got.word_pos, got.last, got.end_of_record,
                        got.error, got.error_flag);
               fail_count = fail_count + 1;
            end
         end
      end
   end

   // Request builder: every field random, then the opcode and chosen operands.
   task automatic push_req(input logic [OPCODE_W-1:0] op, input int arg = -1);
      request_type rq;
      rq.opcode         = op;
      rq.binary_mode    = $urandom_range(0, 1);
      rq.sector_address = PORT_ADDR_W'($urandom);
      rq.char_in        = CHAR_W'($urandom);
      rq.disk_word      = WORD_W'($urandom);
      rq.word_index     = POS_W'($urandom);
      if (arg >= 0) begin
         case (op)
            OP_CONNECT:  rq.binary_mode    = arg[0];
            OP_SET_ADDR: rq.sector_address = PORT_ADDR_W'(arg);
            OP_WRITE:    rq.char_in        = CHAR_W'(arg);
            OP_LOAD:     rq.word_index     = POS_W'(arg);
            default: ;
         endcase
      end
      pending_reqs.push_back(rq);
      req_total = req_total + 1;
   endtask

   // Random well-formed write, read and noise sequences.
   task automatic push_sequence();
      int pick;
      int count;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         push_req(OP_CONNECT);
         if ($urandom_range(0, 1)) push_req(OP_SET_ADDR);
         count = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 300)
                                             : $urandom_range(1, 70);
         repeat (count) push_req(OP_WRITE);
         push_req($urandom_range(0, 1) ? OP_DISC : OP_WEOR);
      end else if (pick < 75) begin
         push_req(OP_CONNECT);
         if ($urandom_range(0, 2) != 0) push_req(OP_SET_ADDR);
         push_req(OP_READ);
         for (int i = 0; i < NUM_WORDS; i++) push_req(OP_LOAD, i);
         count = ($urandom_range(0, 7) == 0) ? $urandom_range(250, 262)
                                             : $urandom_range(1, 70);
         repeat (count) push_req(OP_READ);
         push_req(OP_DISC);
      end else begin
         repeat ($urandom_range(1, 6)) push_req(OPCODE_W'($urandom_range(0, 7)));
      end
   endtask

   // Waits until the block has drained every expected response.
   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
      end
      @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_ATTACHED) cfg_attached = val;
      else cfg_locked = val;
   endtask

   // Stimulus: directed items, then random sequences under several settings.
   initial begin
      int phase_start;
      logic [1:0] settings [5];
      settings = '{2'b00, 2'b10, 2'b11, 2'b01, 2'b10};
      fail_count = 0;
      req_total  = 0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      rsp_stall  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_ATTACHED;
      csr_wdata  = 1'b0;
      req_opcode = OP_CONNECT;
      req_binary_mode    = 1'b0;
      req_sector_address = '0;
      req_char_in        = '0;
      req_disk_word      = '0;
      req_word_index     = '0;
      foreach (sector_mem[i]) sector_mem[i] = '0;
      char_ptr = '0; char_len = '0; cur_addr = '0;
      is_active = 1'b0; is_binary = 1'b0; err_sticky = 1'b0;
      cfg_attached = 1'b0; cfg_locked = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 5; ph++) begin
         write_csr(CSR_ATTACHED, settings[ph][1]);
         write_csr(CSR_LOCKED, settings[ph][0]);
         if (ph == 0) begin
            // Extremes, every opcode, detached read and fill errors, spare opcode.
            push_req(OP_SET_ADDR, 18'h3FFFF);
            push_req(OP_SET_ADDR, 0);
            push_req(OP_CONNECT, 0);
            push_req(OP_WRITE, 63);
            push_req(OP_WRITE, 0);
            push_req(OP_WEOR);
            push_req(OP_READ);
            push_req(OP_SPARE);
            push_req(OP_DISC);
            push_req(OP_CONNECT, 1);
            push_req(OP_LOAD, 0);
            push_req(OP_LOAD, 63);
            push_req(OP_READ);
            push_req(OP_READ);
            push_req(OP_WRITE, 42);
            push_req(OP_DISC);
            push_req(OP_DISC);
         end
         if (ph == 1) begin
            // Address wrap on load completion from the top address.
            push_req(OP_SET_ADDR, 18'h3FFFF);
            push_req(OP_LOAD, 63);
            push_req(OP_READ);
         end
         phase_start = req_total;
         while (req_total - phase_start < 40) push_sequence();
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #8ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
